[src/sul_pkg.sv]
// ----------------------------------------------------------------------------
// sul_pkg
// Shared types, constants and codes for the sorted unique byte list.
// ----------------------------------------------------------------------------
package sul_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int CAP_W       = 5;
    localparam int LIM_W       = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int KEY_W       = 8;
    localparam int POS_W       = 4;
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_SEARCH = 2'd2,
        OP_SHOW   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_DUP      = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_EXEC,
        S_SHOW
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture request, clear show index
        logic compare;    // compare key against every cell
        logic exec;       // apply insert/remove/search, load result
        logic show_step;  // emit one stored entry
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;   // result register can take a new result
        logic is_show;    // held request is a show
        logic empty;      // no entries stored
        logic show_last;  // show index points at the final entry
    } t_dp_stat;

endpackage

[src/sorted_unique_byte_list.sv]
// ----------------------------------------------------------------------------
// sorted_unique_byte_list
// Ascending list of distinct byte keys with insert, remove, search and show.
// ----------------------------------------------------------------------------
//
//  channel   | direction | handshake              | payload
//  ----------+-----------+------------------------+---------------------------
//  request   | in        | i_valid / o_ready      | i_operation, i_key
//  result    | out       | o_valid / i_ready      | o_status, o_position,
//            |           |                        | o_item, o_last
//  config    | in        | i_cfg_valid/o_cfg_ready| i_cfg_data (capacity)
//
//  Insert, remove and search pass through S_IDLE, which accepts the request,
//  S_CMP, which compares the key against all cells at once, then S_EXEC, which
//  shifts the cell chain and loads the result register, then back to S_IDLE.
//  Show is accepted and compared alike, then emits the stored entries one by one
//  through the single read port onto the cell chain; an empty show emits none.
//  A stalled result holds the execute or show step; one further request may be
//  taken while the result waits, then requests are refused until it moves.
//  Reset (synchronous, active low) empties the list and sets capacity to 16;
//  the stored keys themselves are not cleared.
// ----------------------------------------------------------------------------
module sorted_unique_byte_list import sul_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // request channel
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [1:0]       i_operation,
    input  logic [KEY_W-1:0] i_key,
    // result channel
    output logic             o_valid,
    input  logic             i_ready,
    output logic [1:0]       o_status,
    output logic [POS_W-1:0] o_position,
    output logic [KEY_W-1:0] o_item,
    output logic             o_last,
    // capacity register write
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CAP_W-1:0] i_cfg_data
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // capacity writes go straight into the register, so the port is always open
    assign o_cfg_ready = 1'b1;

    // sequencer: owns the request handshake and issues at most one command a cycle
    sul_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd)
    );

    // datapath: cell chain, compare vectors, show index and result register
    sul_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .i_operation (i_operation),
        .i_key       (i_key),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_ready     (i_ready),
        .o_valid     (o_valid),
        .o_status    (o_status),
        .o_position  (o_position),
        .o_item      (o_item),
        .o_last      (o_last)
    );

endmodule

[src/sul_ctrl.sv]
// ----------------------------------------------------------------------------
// sul_ctrl
// Sequencer: accept, compare, execute or step through a show.
// ----------------------------------------------------------------------------
module sul_ctrl import sul_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (!i_stat.is_show) begin
                    n_state = S_EXEC;
                end else if (i_stat.empty) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_SHOW;
                end
            end
            S_EXEC: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_SHOW: begin
                if (i_stat.out_free && i_stat.show_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ready = 1'b0;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_ready    = 1'b1;
                o_cmd.load = i_valid;
            end
            S_CMP: begin
                o_cmd.compare = 1'b1;
            end
            S_EXEC: begin
                o_cmd.exec = i_stat.out_free;
            end
            S_SHOW: begin
                o_cmd.show_step = i_stat.out_free;
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.load, o_cmd.compare, o_cmd.exec, o_cmd.show_step}))
        else $error("more than one datapath command at once");
    a_cmp_follows_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> o_cmd.compare)
        else $error("compare did not follow request capture");
    a_show_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.show_step |-> !i_stat.empty)
        else $error("show step on an empty list");
`endif

endmodule

[src/sul_datapath.sv]
// ----------------------------------------------------------------------------
// sul_datapath
// Cell chain of stored keys with parallel compare, shift, show index,
// capacity register and result register.
// ----------------------------------------------------------------------------
module sul_datapath import sul_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_dp_cmd          i_cmd,
    output t_dp_stat         o_stat,
    input  logic [1:0]       i_operation,
    input  logic [KEY_W-1:0] i_key,
    input  logic             i_cfg_valid,
    input  logic [CAP_W-1:0] i_cfg_data,
    input  logic             i_ready,
    output logic             o_valid,
    output logic [1:0]       o_status,
    output logic [POS_W-1:0] o_position,
    output logic [KEY_W-1:0] o_item,
    output logic             o_last
);

    t_op                          r_op;
    logic [KEY_W-1:0]             r_key;
    logic [MAX_ENTRIES-1:0]       r_match;
    logic [MAX_ENTRIES-1:0]       r_less;
    logic [CNT_W-1:0]             r_count;
    logic [KEY_W-1:0]             r_entries [MAX_ENTRIES];
    logic [CAP_W-1:0]             r_cap;
    logic [IDX_W-1:0]             r_idx;
    logic                         r_o_valid;
    t_status                      r_o_status;
    logic [POS_W-1:0]             r_o_pos;
    logic [KEY_W-1:0]             r_o_item;
    logic                         r_o_last;

    logic [IDX_W-1:0]             match_at;
    logic [IDX_W-1:0]             ins_at;
    logic                         found;
    logic                         empty;
    logic                         full;
    logic [LIM_W-1:0]             limit;
    logic                         show_last;
    logic                         do_ins;
    logic                         do_rem;
    t_status                      res_status;
    logic [IDX_W-1:0]             res_idx;
    logic                         out_free;

    // one-hot match (keys are distinct) and thermometer less-than vector
    always_comb begin
        match_at = '0;
        ins_at   = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (r_match[i]) begin
                match_at = match_at | IDX_W'(i);
            end
            if ((i == 0) ? !r_less[0] : (r_less[(i == 0) ? 0 : i - 1] && !r_less[i])) begin
                ins_at = ins_at | IDX_W'(i);
            end
        end
    end

    assign found     = |r_match;
    assign empty     = (r_count == '0);
    assign limit     = (LIM_W'(r_cap) > LIM_W'(MAX_ENTRIES)) ? LIM_W'(MAX_ENTRIES)
                                                             : LIM_W'(r_cap);
    assign full      = (LIM_W'(r_count) >= limit);
    assign show_last = ((CNT_W'(r_idx) + CNT_W'(1)) == r_count);
    assign out_free  = !r_o_valid || i_ready;

    always_comb begin
        do_ins     = 1'b0;
        do_rem     = 1'b0;
        res_status = ST_NOTFOUND;
        res_idx    = '0;
        case (r_op)
            OP_INSERT: begin
                if (found) begin
                    res_status = ST_DUP;
                    res_idx    = match_at;
                end else if (full) begin
                    res_status = ST_FULL;
                end else begin
                    do_ins     = 1'b1;
                    res_status = ST_DONE;
                    res_idx    = ins_at;
                end
            end
            OP_REMOVE: begin
                if (empty) begin
                    res_status = ST_FULL;
                end else if (found) begin
                    do_rem     = 1'b1;
                    res_status = ST_DONE;
                    res_idx    = match_at;
                end
            end
            default: begin
                if (found) begin
                    res_status = ST_DONE;
                    res_idx    = match_at;
                end
            end
        endcase
    end

    // capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (i_cfg_valid) begin
            r_cap <= i_cfg_data;
        end
    end

    // request capture and compare
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= t_op'(i_operation);
            r_key <= i_key;
        end
        if (i_cmd.compare) begin
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                r_match[i] <= (CNT_W'(i) < r_count) && (r_entries[i] == r_key);
                r_less[i]  <= (CNT_W'(i) < r_count) && (r_entries[i] < r_key);
            end
        end
    end

    // cell chain: shift up on insert, down on remove
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && do_ins) begin
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                if (IDX_W'(i) == ins_at) begin
                    r_entries[i] <= r_key;
                end else if ((i > 0) && (IDX_W'(i) > ins_at)) begin
                    r_entries[i] <= r_entries[(i > 0) ? i - 1 : 0];
                end
            end
        end else if (i_cmd.exec && do_rem) begin
            for (int i = 0; i < MAX_ENTRIES - 1; i++) begin
                if (IDX_W'(i) >= match_at) begin
                    r_entries[i] <= r_entries[i + 1];
                end
            end
        end
    end

    // entry count and show index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_idx   <= '0;
        end else begin
            if (i_cmd.exec && do_ins) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_cmd.exec && do_rem) begin
                r_count <= r_count - CNT_W'(1);
            end
            if (i_cmd.load) begin
                r_idx <= '0;
            end else if (i_cmd.show_step) begin
                r_idx <= r_idx + IDX_W'(1);
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.exec || i_cmd.show_step) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_o_status <= res_status;
            r_o_pos    <= POS_W'(res_idx);
            r_o_item   <= r_key;
            r_o_last   <= 1'b1;
        end else if (i_cmd.show_step) begin
            r_o_status <= ST_DONE;
            r_o_pos    <= POS_W'(r_idx);
            r_o_item   <= r_entries[r_idx];
            r_o_last   <= show_last;
        end
    end

    assign o_stat.out_free  = out_free;
    assign o_stat.is_show   = (r_op == OP_SHOW);
    assign o_stat.empty     = empty;
    assign o_stat.show_last = show_last;

    assign o_valid    = r_o_valid;
    assign o_status   = r_o_status;
    assign o_position = r_o_pos;
    assign o_item     = r_o_item;
    assign o_last     = r_o_last;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_ENTRIES))
        else $error("entry count beyond list depth");
    a_match_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec |-> $onehot0(r_match))
        else $error("key matched in more than one cell");
    a_exec_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec || i_cmd.show_step) |-> out_free)
        else $error("result loaded over a pending result");
    a_ins_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && do_ins) |=> (r_count != '0))
        else $error("count did not grow on insert");
`endif

endmodule

[tb/tb_sorted_unique_byte_list.sv]
// ----------------------------------------------------------------------------
// tb_sorted_unique_byte_list
// Self-checking bench for the sorted unique byte list. It drives insert,
// remove, search and show requests, follows the list contents in a local
// shadow copy and compares every result field against that copy.
// ----------------------------------------------------------------------------
module tb_sorted_unique_byte_list import sul_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 6;
    // settling time for an empty show and the return to idle
    localparam int SETTLE_CYCLES = 6;
    localparam int CYCLE_LIMIT   = 1_500_000;
    localparam int REPORT_LIMIT  = 10;
    localparam int PHASE_COUNT   = 10;
    localparam int PHASE_ITEMS   = 29;

    // traffic mixes for the random phases
    localparam int MIX_FILL  = 0;
    localparam int MIX_DRAIN = 1;
    localparam int MIX_BLEND = 2;

    typedef struct packed {
        t_status          status;
        logic [POS_W-1:0] position;
        logic [KEY_W-1:0] item;
        logic             last;
    } t_result;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_valid     = 1'b0;
    logic             o_ready;
    logic [1:0]       i_operation = OP_INSERT;
    logic [KEY_W-1:0] i_key       = '0;
    logic             o_valid;
    logic             i_ready     = 1'b0;
    logic [1:0]       o_status;
    logic [POS_W-1:0] o_position;
    logic [KEY_W-1:0] o_item;
    logic             o_last;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [CAP_W-1:0] i_cfg_data  = '0;

    // shadow of the list held by the block
    logic [KEY_W-1:0] shadow_keys [MAX_ENTRIES];
    int unsigned      shadow_count = 0;
    logic [CAP_W-1:0] shadow_capacity = CAP_RESET;

    t_result          awaited_results [$];

    int               cycle_count    = 0;
    int               fault_count    = 0;
    int               results_seen   = 0;
    int               capacity_writes = 0;
    int               op_tally [4]   = '{0, 0, 0, 0};
    bit               steady         = 1'b0;

    sorted_unique_byte_list i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_operation (i_operation),
        .i_key       (i_key),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_status    (o_status),
        .o_position  (o_position),
        .o_item      (o_item),
        .o_last      (o_last),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #(HALF_PERIOD);
        i_clk = 1'b1;
        #(HALF_PERIOD);
    end

    // Watchdog: a correct run finishes far below this bound.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still awaited",
                     cycle_count, awaited_results.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one; none in steady phases.
    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Work out the results of one accepted request and advance the shadow list.
    function automatic void predict_request(t_op op, logic [KEY_W-1:0] key);
        int unsigned limit;
        int unsigned at;
        int unsigned i;
        bit          hit;
        t_result     r;
        limit = (shadow_capacity > MAX_ENTRIES) ? MAX_ENTRIES : shadow_capacity;
        hit   = 1'b0;
        at    = 0;
        for (i = 0; i < shadow_count; i++) begin
            if (!hit && shadow_keys[i] == key) begin
                hit = 1'b1;
                at  = i;
            end
        end
        r.item     = key;
        r.last     = 1'b1;
        r.status   = ST_DONE;
        r.position = '0;
        case (op)
            OP_INSERT: begin
                // the duplicate check wins over the full check
                if (hit) begin
                    r.status   = ST_DUP;
                    r.position = at[POS_W-1:0];
                end else if (shadow_count >= limit) begin
                    r.status = ST_FULL;
                end else begin
                    at = 0;
                    while (at < shadow_count && shadow_keys[at] < key)
                        at++;
                    for (i = shadow_count; i > at; i--)
                        shadow_keys[i] = shadow_keys[i-1];
                    shadow_keys[at] = key;
                    shadow_count++;
                    r.position = at[POS_W-1:0];
                end
            end
            OP_REMOVE: begin
                if (shadow_count == 0) begin
                    r.status = ST_FULL;
                end else if (!hit) begin
                    r.status = ST_NOTFOUND;
                end else begin
                    for (i = at; i + 1 < shadow_count; i++)
                        shadow_keys[i] = shadow_keys[i+1];
                    shadow_count--;
                    r.position = at[POS_W-1:0];
                end
            end
            OP_SEARCH: begin
                if (hit)
                    r.position = at[POS_W-1:0];
                else
                    r.status = ST_NOTFOUND;
            end
            default: begin
                // show: one result per stored key, none for an empty list
                for (i = 0; i < shadow_count; i++) begin
                    r.status   = ST_DONE;
                    r.position = i[POS_W-1:0];
                    r.item     = shadow_keys[i];
                    r.last     = (i + 1 == shadow_count);
                    awaited_results.push_back(r);
                end
                return;
            end
        endcase
        awaited_results.push_back(r);
    endfunction

    // Hold the request until it is taken, then record what it should cause.
    task automatic send_request(input t_op op, input logic [KEY_W-1:0] key);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_operation <= op;
        i_key       <= key;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        predict_request(op, key);
        op_tally[op]++;
    endtask

    // Drop the request line and wait until every awaited result is back.
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] value);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        shadow_capacity = value;
        capacity_writes++;
    endtask

    function automatic void report_fault(string text);
        fault_count++;
        if (fault_count <= REPORT_LIMIT)
            $display("cycle %0d: %s", cycle_count, text);
    endfunction

    // Result side: compare each accepted result with the oldest awaited one.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (awaited_results.size() == 0) begin
                report_fault($sformatf(
                    "unexpected result status %0d pos %0d item %0h last %0b",
                    o_status, o_position, o_item, o_last));
            end else begin
                want = awaited_results.pop_front();
                if (o_status !== want.status || o_position !== want.position ||
                    o_item !== want.item || o_last !== want.last)
                    report_fault({
                        $sformatf("result mismatch: expected status %0d pos %0d",
                                  want.status, want.position),
                        $sformatf(" item %0h last %0b,", want.item, want.last),
                        $sformatf(" got status %0d pos %0d item %0h last %0b",
                                  o_status, o_position, o_item, o_last)});
            end
        end
    end

    // Result back-pressure: ready in bursts with random stalls between them.
    initial begin
        int gap;
        while (!i_rst_n)
            @(posedge i_clk);
        forever begin
            gap = pick_gap();
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    end

    // Favour keys already stored so that duplicates, hits and removals occur.
    function automatic logic [KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 9);
        if (shadow_count > 0 && r < 4)
            return shadow_keys[$urandom_range(0, shadow_count - 1)];
        if (r < 6)
            return KEY_W'($urandom_range(0, 31));
        if (r == 6) begin
            case ($urandom_range(0, 3))
                0:       return 8'h00;
                1:       return 8'hFF;
                2:       return 8'h7F;
                default: return 8'h80;
            endcase
        end
        return KEY_W'($urandom_range(0, 255));
    endfunction

    function automatic t_op pick_op(int mix);
        int r;
        r = $urandom_range(0, 99);
        case (mix)
            MIX_FILL: begin
                if (r < 70) return OP_INSERT;
                if (r < 80) return OP_REMOVE;
                if (r < 90) return OP_SEARCH;
            end
            MIX_DRAIN: begin
                if (r < 15) return OP_INSERT;
                if (r < 70) return OP_REMOVE;
                if (r < 85) return OP_SEARCH;
            end
            default: begin
                if (r < 35) return OP_INSERT;
                if (r < 65) return OP_REMOVE;
                if (r < 85) return OP_SEARCH;
            end
        endcase
        return OP_SHOW;
    endfunction

    // Show, remove and search on a list that holds nothing.
    task automatic test_empty_list();
        send_request(OP_SHOW, 8'hC3);
        send_request(OP_REMOVE, 8'h5A);
        send_request(OP_SEARCH, 8'h00);
    endtask

    // Extreme keys, a duplicate, misses, a full show and a drain to empty.
    task automatic test_extreme_keys();
        send_request(OP_INSERT, 8'hFF);
        send_request(OP_INSERT, 8'h00);
        send_request(OP_INSERT, 8'h80);
        send_request(OP_INSERT, 8'hFF);
        send_request(OP_SEARCH, 8'h00);
        send_request(OP_SEARCH, 8'hFF);
        send_request(OP_SEARCH, 8'h4D);
        send_request(OP_REMOVE, 8'h4D);
        send_request(OP_SHOW, 8'h00);
        send_request(OP_REMOVE, 8'h00);
        send_request(OP_REMOVE, 8'hFF);
        send_request(OP_REMOVE, 8'h80);
    endtask

    // Zero capacity, capacity one, duplicate ahead of full, clamped capacity.
    task automatic test_capacity_limits();
        write_capacity(5'd0);
        send_request(OP_INSERT, 8'h0A);
        write_capacity(5'd1);
        send_request(OP_INSERT, 8'h0A);
        send_request(OP_INSERT, 8'h14);
        send_request(OP_INSERT, 8'h0A);
        send_request(OP_REMOVE, 8'h0A);
        write_capacity(5'd31);
        send_request(OP_INSERT, 8'h2A);
        send_request(OP_SHOW, 8'h55);
    endtask

    // Phases of random traffic, each under its own capacity and request mix.
    task automatic test_random_traffic();
        int               phase;
        int               n;
        int               mix;
        logic [CAP_W-1:0] cap;
        t_op              op;
        for (phase = 0; phase < PHASE_COUNT; phase++) begin
            case (phase)
                0:       begin cap = 5'd31; mix = MIX_FILL;  end
                1:       begin cap = 5'd31; mix = MIX_FILL;  end
                2:       begin cap = 5'd3;  mix = MIX_BLEND; end // below the count
                3:       begin cap = 5'd16; mix = MIX_DRAIN; end
                4:       begin cap = 5'd0;  mix = MIX_BLEND; end
                5:       begin cap = 5'd1;  mix = MIX_FILL;  end
                6:       begin cap = 5'd16; mix = MIX_DRAIN; end
                7:       begin cap = 5'd20; mix = MIX_FILL;  end
                8:       begin cap = CAP_W'($urandom_range(0, 31)); mix = MIX_BLEND; end
                default: begin cap = 5'd16; mix = MIX_BLEND; end
            endcase
            write_capacity(cap);
            // a couple of phases run with no gaps on either side
            steady = (phase == 2 || phase == 6);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                op = pick_op(mix);
                send_request(op, pick_key());
            end
            steady = 1'b0;
        end
    endtask

    initial begin
        for (int i = 0; i < MAX_ENTRIES; i++)
            shadow_keys[i] = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_list();
        test_extreme_keys();
        test_capacity_limits();
        test_random_traffic();
        wait_idle();

        $display("requests: %0d insert, %0d remove, %0d search, %0d show; %0d results checked",
                 op_tally[OP_INSERT], op_tally[OP_REMOVE], op_tally[OP_SEARCH],
                 op_tally[OP_SHOW], results_seen);
        $display("capacity written %0d times, %0d faults found",
                 capacity_writes, fault_count);
        if (fault_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

[files.f]
src/sul_pkg.sv
src/sul_ctrl.sv
src/sul_datapath.sv
src/sorted_unique_byte_list.sv
tb/tb_sorted_unique_byte_list.sv
